FILE: src/tlbr_pkg.sv
// Shared types and constants for the translation buffer with FIFO/LRU replacement.
`timescale 1ns / 1ps

package tlbr_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 16;
    localparam int FIELD_W         = 16;
    localparam int OPCODE_W        = 2;
    localparam int CFG_W           = 5;

    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FLUSH  = 2'd2;

    localparam logic REG_ENTRIES_IN_USE = 1'b0;
    localparam logic REG_POLICY         = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [FIELD_W-1:0]  page_number;
        logic [FIELD_W-1:0]  frame_number;
    } tlbr_req_t;

    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] found_frame;
        logic               evicted;
        logic [FIELD_W-1:0] evicted_page;
    } tlbr_rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } tlbr_state_t;

endpackage

FILE: src/tlbr_cell.sv
// One list position: holds a page and frame, compares the page, takes its left neighbor on shift.
`timescale 1ns / 1ps

module tlbr_cell
    import tlbr_pkg::*;
#(
    parameter int PAGE_W = PAGE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               shift,
    input  logic [PAGE_W-1:0]  left_page,
    input  logic [FIELD_W-1:0] left_frame,
    input  logic [PAGE_W-1:0]  key,
    output logic [PAGE_W-1:0]  page,
    output logic [FIELD_W-1:0] frame,
    output logic               match
);

    logic [PAGE_W-1:0]  page_reg;
    logic [FIELD_W-1:0] frame_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            page_reg  <= left_page;
            frame_reg <= left_frame;
        end
    end

    assign page  = page_reg;
    assign frame = frame_reg;
    assign match = (page_reg == key);

endmodule

FILE: src/tlb_fifo_lru_replacement.sv
// Top level of the translation buffer: control, fill count and the chain of entry cells.
`timescale 1ns / 1ps

// Translation buffer whose entries form a recency-ordered list, front is newest.
// Request channel (req_valid / req_stall / req) carries lookup, insert or flush;
// every request yields exactly one item on the response channel
// (rsp_valid / rsp_stall / rsp).
// Each item is first taken into the input registers, after which all
// cells compare the page in parallel and the chain shifts by one position.
// req_stall is high during the compare cycle, so no new item is taken until the
// last one is through. The response is registered as the chain shifts.
// The response sits in an output register; while rsp_stall holds it, the block
// still takes the next item but keeps that item in the compare cycle until the
// output register frees up.
// Configuration: cfg_we / cfg_index / cfg_data, to be written by the user only
// while the block is idle; the block itself does not enforce this. Index 0 sets
// the entries in use (0 disables the buffer), index 1 the policy (0 FIFO, 1 LRU).
// Reset empties the list, sets 16 entries in use and FIFO policy; entry contents
// are not cleared and need no clearing pass.
module tlb_fifo_lru_replacement
    import tlbr_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  tlbr_req_t        req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output tlbr_rsp_t        rsp,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int STORE_W = (PAGE_BITS < FIELD_W) ? PAGE_BITS : FIELD_W;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    tlbr_state_t state_reg, state_next;

    logic [CFG_W-1:0]    entries_reg;
    logic                policy_reg;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [STORE_W-1:0]  key_reg;
    logic [FIELD_W-1:0]  frame_reg;
    tlbr_rsp_t           rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                advance;
    logic [CMP_W-1:0]    cap_wide;
    logic [CNT_W-1:0]    cap;
    logic [CNT_W-1:0]    vis_n;
    logic [CNT_W-1:0]    ins_pos;
    logic                ins_en;
    logic                evict;
    logic [MAX_ENTRIES-1:0] visible;
    logic [MAX_ENTRIES-1:0] hits;
    logic [MAX_ENTRIES-1:0] first_hit;
    logic [MAX_ENTRIES-1:0] shift_mask;
    logic [FIELD_W-1:0]  sel_frame;
    logic [STORE_W-1:0]  tail_page;
    logic [FIELD_W-1:0]  head_frame;

    logic [STORE_W-1:0]  cell_page  [MAX_ENTRIES];
    logic [FIELD_W-1:0]  cell_frame [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_match;

    // Chain of cells; the front cell takes the new head entry.
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [STORE_W-1:0] left_page;
        logic [FIELD_W-1:0] left_frame;

        if (i == 0)
        begin : g_front
            assign left_page  = key_reg;
            assign left_frame = head_frame;
        end
        else
        begin : g_rest
            assign left_page  = cell_page[i-1];
            assign left_frame = cell_frame[i-1];
        end

        tlbr_cell #(
            .PAGE_W (STORE_W)
        ) u_cell (
            .clk        (clk),
            .shift      (advance & shift_mask[i]),
            .left_page  (left_page),
            .left_frame (left_frame),
            .key        (key_reg),
            .page       (cell_page[i]),
            .frame      (cell_frame[i]),
            .match      (cell_match[i])
        );
    end

    always_comb
    begin
        cap_wide = (CMP_W'(entries_reg) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES)
                                                              : CMP_W'(entries_reg);
        cap      = cap_wide[CNT_W-1:0];
        vis_n    = (fill_reg < cap) ? fill_reg : cap;
        ins_en   = (op_reg == OP_INSERT) && (cap != '0);
        evict    = ins_en && (vis_n >= cap);
        ins_pos  = evict ? CNT_W'(vis_n - CNT_W'(1)) : vis_n;

        sel_frame = '0;
        tail_page = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            visible[i] = (CNT_W'(i) < vis_n);
        end
        hits      = cell_match & visible;
        first_hit = hits & (~hits + MAX_ENTRIES'(1));
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            sel_frame = sel_frame | (cell_frame[i] & {FIELD_W{first_hit[i]}});
            tail_page = tail_page
                      | (cell_page[i] & {STORE_W{CNT_W'(i) == CNT_W'(vis_n - CNT_W'(1))}});
        end

        head_frame = frame_reg;
        shift_mask = '0;
        fill_next  = fill_reg;
        rsp_next   = '0;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                head_frame       = sel_frame;
                rsp_next.hit     = |hits;
                rsp_next.found_frame = sel_frame;
                if (policy_reg == POLICY_LRU && (|hits))
                begin
                    shift_mask = first_hit | (first_hit - MAX_ENTRIES'(1));
                end
            end
            OP_INSERT:
            begin
                if (ins_en)
                begin
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        shift_mask[i] = (CNT_W'(i) <= ins_pos);
                    end
                    fill_next = CNT_W'(ins_pos + CNT_W'(1));
                end
                rsp_next.evicted = evict;
                if (evict)
                begin
                    rsp_next.evicted_page = FIELD_W'(tail_page);
                end
            end
            OP_FLUSH:
            begin
                fill_next = '0;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    // Control sequencer: take an item, then compare and shift once the output is free.
    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        advance    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    advance    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            entries_reg   <= ENTRIES_RESET;
            policy_reg    <= POLICY_FIFO;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                fill_reg <= fill_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ENTRIES_IN_USE: entries_reg <= cfg_data;
                    REG_POLICY:         policy_reg  <= cfg_data[0];
                    default:            policy_reg  <= policy_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            op_reg    <= req.opcode;
            key_reg   <= req.page_number[STORE_W-1:0];
            frame_reg <= req.frame_number;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: src/tlbr_checker.sv
// Port-level checks for the translation buffer, bound to the top level.
`timescale 1ns / 1ps

module tlbr_port_checks
    import tlbr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input tlbr_rsp_t rsp
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous item still in work");

    a_hit_excludes_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.hit && rsp.evicted))
        else $error("response reports both hit and eviction");

    a_miss_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> rsp.found_frame == '0)
        else $error("found frame nonzero on miss");

    a_no_evict_zero_page: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.evicted |-> rsp.evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response dropped or changed");

endmodule

bind tlb_fifo_lru_replacement tlbr_port_checks u_tlbr_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: sim/tlbr_checker.sv
// Checker that tracks the translation buffer list, predicts each response and compares it.
`timescale 1ns / 1ps

module tlbr_checker
    import tlbr_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_stall,
    input  tlbr_req_t        req,
    input  logic             rsp_valid,
    input  logic             rsp_stall,
    input  tlbr_rsp_t        rsp,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               replies_due,
    output int               hit_total,
    output int               evict_total
);

    logic [FIELD_W-1:0] list_page  [MAX_ENTRIES];
    logic [FIELD_W-1:0] list_frame [MAX_ENTRIES];
    int                 list_fill;
    logic [CFG_W-1:0]   entries_cfg;
    logic               policy_cfg;
    tlbr_rsp_t          tlb_replies[$];
    tlbr_rsp_t          want;
    int                 mismatches;
    int                 hits_seen;
    int                 evicts_seen;

    initial
    begin
        fail_count  = 0;
        replies_due = 0;
        hit_total   = 0;
        evict_total = 0;
        mismatches  = 0;
        hits_seen   = 0;
        evicts_seen = 0;
        list_fill   = 0;
        entries_cfg = ENTRIES_RESET;
        policy_cfg  = POLICY_FIFO;
    end

    task automatic promote(input int pos);
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] f;
        p = list_page[pos];
        f = list_frame[pos];
        for (int i = pos; i > 0; i--)
        begin
            list_page[i]  = list_page[i-1];
            list_frame[i] = list_frame[i-1];
        end
        list_page[0]  = p;
        list_frame[0] = f;
    endtask

    task automatic apply_tlb_op(input tlbr_req_t r, output tlbr_rsp_t e);
        int cap;
        int vis;
        bit found;
        e     = '0;
        found = 1'b0;
        cap   = (int'(entries_cfg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(entries_cfg);
        vis   = (list_fill < cap) ? list_fill : cap;
        case (r.opcode)
            OP_LOOKUP:
            begin
                if (cap != 0)
                begin
                    for (int i = 0; i < vis; i++)
                    begin
                        if (!found && list_page[i] == r.page_number)
                        begin
                            found         = 1'b1;
                            e.hit         = 1'b1;
                            e.found_frame = list_frame[i];
                            if (policy_cfg == POLICY_LRU)
                                promote(i);
                        end
                    end
                end
            end
            OP_INSERT:
            begin
                if (cap != 0)
                begin
                    list_fill = vis;
                    if (vis >= cap)
                    begin
                        e.evicted      = 1'b1;
                        e.evicted_page = list_page[vis-1];
                        list_fill      = vis - 1;
                    end
                    list_page[list_fill]  = r.page_number;
                    list_frame[list_fill] = r.frame_number;
                    promote(list_fill);
                    list_fill++;
                end
            end
            OP_FLUSH:
            begin
                list_fill = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_fill   = 0;
            entries_cfg = ENTRIES_RESET;
            policy_cfg  = POLICY_FIFO;
            tlb_replies.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ENTRIES_IN_USE)
                    entries_cfg = cfg_data;
                else
                    policy_cfg = cfg_data[0];
            end
            if (req_valid && !req_stall)
            begin
                apply_tlb_op(req, want);
                hits_seen   += want.hit;
                evicts_seen += want.evicted;
                tlb_replies.push_back(want);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (tlb_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] response with none due: hit=%0b frame=%h evicted=%0b page=%h",
                                 $realtime, rsp.hit, rsp.found_frame, rsp.evicted,
                                 rsp.evicted_page);
                end
                else
                begin
                    want = tlb_replies.pop_front();
                    if (rsp.hit !== want.hit || rsp.found_frame !== want.found_frame ||
                        rsp.evicted !== want.evicted || rsp.evicted_page !== want.evicted_page)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch: hit %0b/%0b frame %h/%h evicted %0b/%0b page %h/%h (expected/actual)",
                                     $realtime, want.hit, rsp.hit, want.found_frame,
                                     rsp.found_frame, want.evicted, rsp.evicted,
                                     want.evicted_page, rsp.evicted_page);
                    end
                end
            end
        end
        replies_due <= tlb_replies.size();
        fail_count  <= mismatches;
        hit_total   <= hits_seen;
        evict_total <= evicts_seen;
    end

endmodule

FILE: sim/tlb_fifo_lru_replacement_tb.sv
// Testbench top for the FIFO/LRU translation buffer: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tlb_fifo_lru_replacement_tb;
    import tlbr_pkg::*;

    localparam int                  IDLE_PCT    = 17;
    localparam int                  DOG_LIMIT   = 2000;
    localparam int                  PHASES      = 8;
    localparam int                  PHASE_ITEMS = 150;
    localparam int                  POOL_SIZE   = 24;
    localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    tlbr_req_t        req       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    tlbr_rsp_t        rsp;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = REG_ENTRIES_IN_USE;
    logic [CFG_W-1:0] cfg_data  = '0;

    int fail_count;
    int replies_due;
    int hit_total;
    int evict_total;
    bit quiet       = 1'b0;
    int idle_cycles = 0;
    int item_total  = 0;
    int write_total = 0;

    logic [FIELD_W-1:0] page_pool [POOL_SIZE];
    logic [CFG_W-1:0]   phase_cap;
    logic               phase_policy;
    int                 pick;

    tlb_fifo_lru_replacement u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tlbr_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .replies_due (replies_due),
        .hit_total   (hit_total),
        .evict_total (evict_total)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= DOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic put(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] page,
                       input logic [FIELD_W-1:0] frame);
        tlbr_req_t item;
        item.opcode       = op;
        item.page_number  = page;
        item.frame_number = frame;
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        item_total++;
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        write_total++;
    endtask

    task automatic set_mode(input logic [CFG_W-1:0] cap, input logic policy);
        settle();
        write_reg(REG_ENTRIES_IN_USE, cap);
        write_reg(REG_POLICY, policy);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put(OP_LOOKUP, 16'h0000, 16'h0000);
        put(OP_INSERT, 16'hFFFF, 16'hFFFF);
        put(OP_INSERT, 16'h0000, 16'h0000);
        put(OP_LOOKUP, 16'hFFFF, 16'h0000);
        put(OP_INSERT, 16'h0000, 16'hAAAA);
        put(OP_LOOKUP, 16'h0000, 16'hFFFF);
        put(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        put(OP_FLUSH, 16'h5555, 16'h5555);
        put(OP_LOOKUP, 16'hFFFF, 16'h0000);

        set_mode(5'd2, POLICY_LRU);
        put(OP_INSERT, 16'h0001, 16'h0011);
        put(OP_INSERT, 16'h0002, 16'h0022);
        put(OP_LOOKUP, 16'h0001, 16'h0000);
        put(OP_INSERT, 16'h0003, 16'h0033);

        set_mode(5'd2, POLICY_FIFO);
        put(OP_INSERT, 16'h0004, 16'h0044);

        set_mode(5'd16, POLICY_FIFO);
        put(OP_INSERT, 16'h0005, 16'h0055);
        put(OP_INSERT, 16'h0006, 16'h0066);
        put(OP_INSERT, 16'h0007, 16'h0077);

        set_mode(5'd1, POLICY_FIFO);
        put(OP_LOOKUP, 16'h0003, 16'h0000);
        put(OP_LOOKUP, 16'h0007, 16'h0000);
        put(OP_INSERT, 16'h0008, 16'h0088);

        set_mode(5'd0, POLICY_LRU);
        put(OP_LOOKUP, 16'h0008, 16'h0000);
        put(OP_INSERT, 16'h0009, 16'h0099);
        put(OP_FLUSH, 16'h0000, 16'h0000);

        set_mode(5'd31, POLICY_LRU);
        put(OP_INSERT, 16'h000A, 16'h00AA);
        put(OP_LOOKUP, 16'h000A, 16'h0000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            pick = $urandom_range(9);
            case (pick)
                0:       phase_cap = 5'd0;
                1, 2:    phase_cap = CFG_W'($urandom_range(1, 2));
                3, 4, 5: phase_cap = CFG_W'($urandom_range(3, 6));
                6, 7:    phase_cap = CFG_W'($urandom_range(7, 16));
                8:       phase_cap = 5'd16;
                default: phase_cap = CFG_W'($urandom_range(17, 31));
            endcase
            if (ph == 0)
                phase_cap = 5'd16;
            phase_policy = ($urandom_range(1) == 1) ? POLICY_LRU : POLICY_FIFO;
            set_mode(phase_cap, phase_policy);
            quiet = (ph == 3);
            for (int i = 0; i < POOL_SIZE; i++)
                page_pool[i] = FIELD_W'($urandom);
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 48)
                    put(OP_LOOKUP,
                        ($urandom_range(99) < 80) ? page_pool[$urandom_range(POOL_SIZE - 1)]
                                                  : FIELD_W'($urandom),
                        FIELD_W'($urandom));
                else if (pick < 93)
                    put(OP_INSERT,
                        ($urandom_range(99) < 80) ? page_pool[$urandom_range(POOL_SIZE - 1)]
                                                  : FIELD_W'($urandom),
                        FIELD_W'($urandom));
                else if (pick < 97)
                    put(OP_FLUSH, FIELD_W'($urandom), FIELD_W'($urandom));
                else
                    put(OP_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom));
            end
        end
        quiet = 1'b0;

        settle();
        repeat (8) @(posedge clk);
        $display("Covered %0d items and %0d register writes, capacities 0 to 31, FIFO and LRU.",
                 item_total, write_total);
        $display("Expected %0d hits and %0d evictions across the run.", hit_total, evict_total);
        if (fail_count == 0 && replies_due == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
